@@ rtl/apmm_pkg.sv @@
package apmm_pkg;

  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned GAIN_REG_W = 3 * GAIN_W;
  localparam int unsigned LIMIT_W  = 31;
  localparam int unsigned CFG_W    = GAIN_REG_W;
  localparam int unsigned IN_W     = 18;
  localparam int unsigned ERR_W    = IN_W + 1;
  localparam int unsigned DT_W     = 16;
  localparam int unsigned THR_W    = 13;
  localparam int unsigned Q12_W    = 32;
  localparam int unsigned MUL_A_W  = GAIN_W + 1;
  localparam int unsigned MUL_B_W  = Q12_W;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W    = MUL_P_W + 2;

  localparam logic signed [ERR_W-1:0] Q12_PI     = 19'sd12868;
  localparam logic signed [ERR_W-1:0] Q12_TWO_PI = 19'sd25736;
  localparam logic [THR_W-1:0]        MOTOR_FULL = 13'd4096;
  localparam logic [LIMIT_W-1:0]      LIMIT_RESET = 31'd102400;

  localparam logic KIND_AXIS = 1'b0;
  localparam logic KIND_MIX  = 1'b1;

  typedef enum logic [1:0] {
    AXIS_ROLL  = 2'd0,
    AXIS_PITCH = 2'd1,
    AXIS_YAW   = 2'd2,
    AXIS_NONE  = 2'd3
  } apmm_axis_t;

  typedef enum logic [1:0] {
    REG_KP    = 2'd0,
    REG_KI    = 2'd1,
    REG_KD    = 2'd2,
    REG_LIMIT = 2'd3
  } apmm_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDT,
    S_INT,
    S_PI,
    S_PD,
    S_SUM,
    S_MIX
  } apmm_state_t;

endpackage

@@ rtl/apmm_mul.sv @@
module apmm_mul (
  input  logic                                 clk,
  input  logic signed [apmm_pkg::MUL_A_W-1:0]  a,
  input  logic signed [apmm_pkg::MUL_B_W-1:0]  b,
  output logic signed [apmm_pkg::MUL_P_W-1:0]  p_r
);
  import apmm_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

@@ rtl/attitude_pid_motor_mixer.sv @@
// channel | handshake            | payload
// in      | in_valid / in_ready  | kind, axis, setpoint, angle, rate, time_step,
//         |                      | hold_integral, yaw_angle_mode, throttle
// out     | out_valid / out_ready| pid_output, motor_front..motor_fourth
// cfg     | cfg_wr_en            | cfg_index, cfg_data
//
// Axis beat: one registered 17x32 multiplier is used four times (error*dt, P, I,
// D terms) over S_EDT, S_INT, S_PI, S_PD, S_SUM. Mix and invalid-axis beats: S_MIX.
// Result sits in an output register; the next beat is taken while it waits,
// the sequencer only holds in its final step if that register is still full.
// rst_n (sync, low) clears control, gains, limit (to 25.0) and both stores.
module attitude_pid_motor_mixer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  input  logic [1:0]                         in_axis,
  input  logic signed [apmm_pkg::IN_W-1:0]   in_setpoint,
  input  logic signed [apmm_pkg::IN_W-1:0]   in_angle,
  input  logic signed [apmm_pkg::IN_W-1:0]   in_rate,
  input  logic [apmm_pkg::DT_W-1:0]          in_time_step,
  input  logic                               in_hold_integral,
  input  logic                               in_yaw_angle_mode,
  input  logic [apmm_pkg::THR_W-1:0]         in_throttle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [apmm_pkg::Q12_W-1:0]  out_pid_output,
  output logic [apmm_pkg::THR_W-1:0]         out_motor_front,
  output logic [apmm_pkg::THR_W-1:0]         out_motor_second,
  output logic [apmm_pkg::THR_W-1:0]         out_motor_third,
  output logic [apmm_pkg::THR_W-1:0]         out_motor_fourth,
  input  logic                               cfg_wr_en,
  input  logic [1:0]                         cfg_index,
  input  logic [apmm_pkg::CFG_W-1:0]         cfg_data
);
  import apmm_pkg::*;

  function automatic logic [THR_W-1:0] motor_clamp(input logic signed [Q12_W+2:0] v);
    logic [THR_W-1:0] m;
    if (v < 0) begin
      m = '0;
    end else if (v > $signed({22'd0, MOTOR_FULL})) begin
      m = MOTOR_FULL;
    end else begin
      m = v[THR_W-1:0];
    end
    return m;
  endfunction

  apmm_state_t state_r, state_nxt;

  logic [GAIN_REG_W-1:0] kp_r, ki_r, kd_r;
  logic [LIMIT_W-1:0]    limit_r;

  logic signed [Q12_W-1:0] integ_store_r [3];
  logic signed [Q12_W-1:0] out_store_r   [3];

  logic [1:0]              axis_r;
  logic                    kind_r;
  logic                    hold_r;
  logic                    rate_mode_r;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic signed [IN_W-1:0]  rate_r;
  logic [DT_W-1:0]         dt_r;
  logic [THR_W-1:0]        thr_r;
  logic signed [Q12_W-1:0] integ_r, integ_nxt;
  logic signed [ACC_W-1:0] acc_r;

  logic                    out_valid_r;
  logic signed [Q12_W-1:0] pid_r, pid_nxt;
  logic [THR_W-1:0]        m0_r, m1_r, m2_r, m3_r;
  logic [THR_W-1:0]        m0_nxt, m1_nxt, m2_nxt, m3_nxt;

  logic                    accept;
  logic                    out_free;
  logic                    out_load;
  logic                    mix_load;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  logic [GAIN_W-1:0]       kp_g, ki_g, kd_g;
  logic signed [ERR_W-1:0] err_raw;
  logic signed [19:0]      ed;
  logic signed [Q12_W+1:0] integ_sum, lim_pos, lim_neg;
  logic signed [ACC_W-1:0] acc_fin;
  logic signed [ACC_W-9:0] acc_sh;
  logic signed [Q12_W+2:0] thr_x, r_x, p_x, y_x;

  apmm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    case (axis_r)
      AXIS_ROLL: begin
        kp_g = kp_r[GAIN_W-1:0];
        ki_g = ki_r[GAIN_W-1:0];
        kd_g = kd_r[GAIN_W-1:0];
      end
      AXIS_PITCH: begin
        kp_g = kp_r[2*GAIN_W-1:GAIN_W];
        ki_g = ki_r[2*GAIN_W-1:GAIN_W];
        kd_g = kd_r[2*GAIN_W-1:GAIN_W];
      end
      default: begin
        kp_g = kp_r[3*GAIN_W-1:2*GAIN_W];
        ki_g = ki_r[3*GAIN_W-1:2*GAIN_W];
        kd_g = kd_r[3*GAIN_W-1:2*GAIN_W];
      end
    endcase
  end

  // error at accept, with the single pi wrap on yaw angle mode
  always_comb begin
    if (in_axis == AXIS_YAW && !in_yaw_angle_mode) begin
      err_raw = ERR_W'(in_setpoint) - ERR_W'(in_rate);
      err_nxt = err_raw;
    end else begin
      err_raw = ERR_W'(in_setpoint) - ERR_W'(in_angle);
      if (in_axis == AXIS_YAW && err_raw <= -Q12_PI) begin
        err_nxt = err_raw + Q12_TWO_PI;
      end else if (in_axis == AXIS_YAW && err_raw > Q12_PI) begin
        err_nxt = err_raw - Q12_TWO_PI;
      end else begin
        err_nxt = err_raw;
      end
    end
  end

  // integrator update from err*dt, floor of Q.28 >> 16
  always_comb begin
    ed        = prod[35:16];
    integ_sum = (Q12_W+2)'(integ_store_r[axis_r]) + (Q12_W+2)'(ed);
    lim_pos   = $signed({3'b000, limit_r});
    lim_neg   = -lim_pos;
    if (hold_r) begin
      integ_nxt = '0;
    end else if (integ_sum > lim_pos) begin
      integ_nxt = lim_pos[Q12_W-1:0];
    end else if (integ_sum < lim_neg) begin
      integ_nxt = lim_neg[Q12_W-1:0];
    end else begin
      integ_nxt = integ_sum[Q12_W-1:0];
    end
  end

  // final sum, floor >> 8, saturate to 32 bits
  always_comb begin
    acc_fin = acc_r - ACC_W'(prod);
    acc_sh  = acc_fin[ACC_W-1:8];
    if (acc_sh[ACC_W-9:Q12_W-1] != {(ACC_W-8-Q12_W+1){acc_sh[ACC_W-9]}}) begin
      pid_nxt = acc_sh[ACC_W-9] ? {1'b1, {(Q12_W-1){1'b0}}} : {1'b0, {(Q12_W-1){1'b1}}};
    end else begin
      pid_nxt = acc_sh[Q12_W-1:0];
    end
  end

  always_comb begin
    thr_x  = $signed({22'd0, thr_r});
    r_x    = (Q12_W+3)'(out_store_r[AXIS_ROLL]);
    p_x    = (Q12_W+3)'(out_store_r[AXIS_PITCH]);
    y_x    = (Q12_W+3)'(out_store_r[AXIS_YAW]);
    m0_nxt = motor_clamp(thr_x + p_x + r_x - y_x);
    m1_nxt = motor_clamp(thr_x + p_x - r_x + y_x);
    m2_nxt = motor_clamp(thr_x - p_x - r_x - y_x);
    m3_nxt = motor_clamp(thr_x - p_x + r_x + y_x);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_MIX || in_axis == AXIS_NONE) begin
            state_nxt = S_MIX;
          end else begin
            state_nxt = S_EDT;
          end
        end
      end
      S_EDT:   state_nxt = S_INT;
      S_INT:   state_nxt = S_PI;
      S_PI:    state_nxt = S_PD;
      S_PD:    state_nxt = S_SUM;
      S_SUM:   state_nxt = out_free ? S_IDLE : S_SUM;
      S_MIX:   state_nxt = out_free ? S_IDLE : S_MIX;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands and load strobes
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    mix_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_EDT: begin
        mul_a = $signed({1'b0, dt_r});
        mul_b = MUL_B_W'(err_r);
      end
      S_INT: begin
        mul_a = $signed({1'b0, rate_mode_r ? kd_g : kp_g});
        mul_b = MUL_B_W'(err_r);
      end
      S_PI: begin
        mul_a = $signed({1'b0, ki_g});
        mul_b = integ_r;
      end
      S_PD: begin
        mul_a = $signed({1'b0, kd_g});
        mul_b = rate_mode_r ? '0 : MUL_B_W'(rate_r);
      end
      S_SUM: begin
        // keep the D product in place while the output register is full
        mul_a    = $signed({1'b0, kd_g});
        mul_b    = rate_mode_r ? '0 : MUL_B_W'(rate_r);
        out_load = out_free;
      end
      S_MIX: begin
        out_load = out_free;
        mix_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= '0;
      ki_r    <= '0;
      kd_r    <= '0;
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KP:    kp_r    <= cfg_data;
        REG_KI:    ki_r    <= cfg_data;
        REG_KD:    kd_r    <= cfg_data;
        REG_LIMIT: limit_r <= cfg_data[LIMIT_W-1:0];
        default:   limit_r <= limit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r      <= in_kind;
      axis_r      <= in_axis;
      hold_r      <= in_hold_integral;
      rate_mode_r <= (in_axis == AXIS_YAW) && !in_yaw_angle_mode;
      err_r       <= err_nxt;
      rate_r      <= in_rate;
      dt_r        <= in_time_step;
      thr_r       <= in_throttle;
    end
    if (state_r == S_INT) begin
      integ_r <= integ_nxt;
    end
    if (state_r == S_PI) begin
      acc_r <= ACC_W'(prod);
    end else if (state_r == S_PD) begin
      acc_r <= acc_r + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        integ_store_r[i] <= '0;
        out_store_r[i]   <= '0;
      end
    end else begin
      if (state_r == S_INT) begin
        integ_store_r[axis_r] <= integ_nxt;
      end
      if (state_r == S_SUM && out_free) begin
        out_store_r[axis_r] <= pid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (mix_load && kind_r == KIND_MIX) begin
        pid_r <= '0;
        m0_r  <= m0_nxt;
        m1_r  <= m1_nxt;
        m2_r  <= m2_nxt;
        m3_r  <= m3_nxt;
      end else begin
        pid_r <= mix_load ? '0 : pid_nxt;
        m0_r  <= '0;
        m1_r  <= '0;
        m2_r  <= '0;
        m3_r  <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pid_output   = pid_r;
  assign out_motor_front  = m0_r;
  assign out_motor_second = m1_r;
  assign out_motor_third  = m2_r;
  assign out_motor_fourth = m3_r;

endmodule

@@ rtl/apmm_checker.sv @@
module apmm_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [apmm_pkg::Q12_W-1:0]  out_pid_output,
  input logic [apmm_pkg::THR_W-1:0]         out_motor_front,
  input logic [apmm_pkg::THR_W-1:0]         out_motor_second,
  input logic [apmm_pkg::THR_W-1:0]         out_motor_third,
  input logic [apmm_pkg::THR_W-1:0]         out_motor_fourth
);
  import apmm_pkg::*;

  // not ready again in the cycle right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pid_output)
      && $stable(out_motor_front) && $stable(out_motor_fourth))
    else $error("stalled result changed");

  a_motor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_motor_front <= MOTOR_FULL && out_motor_second <= MOTOR_FULL
      && out_motor_third <= MOTOR_FULL && out_motor_fourth <= MOTOR_FULL)
    else $error("motor command above full scale");

  // axis beats carry no motors, mix beats carry no pid output
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pid_output != 0 |-> out_motor_front == 0
      && out_motor_second == 0 && out_motor_third == 0 && out_motor_fourth == 0)
    else $error("pid output and motors both set");

endmodule

bind attitude_pid_motor_mixer apmm_checker u_apmm_checker (.*);

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import apmm_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam longint INT32_HI = 64'sd2147483647;
  localparam longint INT32_LO = -64'sd2147483648;

  typedef struct {
    logic                    kind;
    apmm_axis_t              axis;
    logic signed [IN_W-1:0]  setpoint;
    logic signed [IN_W-1:0]  angle;
    logic signed [IN_W-1:0]  rate;
    logic [DT_W-1:0]         time_step;
    logic                    hold_integral;
    logic                    yaw_angle_mode;
    logic [THR_W-1:0]        throttle;
  } pid_request_t;

  typedef struct {
    logic signed [Q12_W-1:0] pid_output;
    logic [THR_W-1:0]        motor_front;
    logic [THR_W-1:0]        motor_second;
    logic [THR_W-1:0]        motor_third;
    logic [THR_W-1:0]        motor_fourth;
  } pid_result_t;

  class attitude_scoreboard;
    logic [GAIN_REG_W-1:0] kp_reg;
    logic [GAIN_REG_W-1:0] ki_reg;
    logic [GAIN_REG_W-1:0] kd_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    int                    integ_store[3];
    int                    axis_out_store[3];
    pid_result_t           expected_q[$];
    int                    errors;

    function new();
      kp_reg    = '0;
      ki_reg    = '0;
      kd_reg    = '0;
      limit_reg = LIMIT_RESET;
      errors    = 0;
      for (int i = 0; i < 3; i++) begin
        integ_store[i]    = 0;
        axis_out_store[i] = 0;
      end
    endfunction

    function void write_reg(apmm_reg_t idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_KP:    kp_reg = data;
        REG_KI:    ki_reg = data;
        REG_KD:    kd_reg = data;
        REG_LIMIT: limit_reg = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [THR_W-1:0] motor_clamp(longint v);
      if (v < 0) return '0;
      if (v > longint'(MOTOR_FULL)) return MOTOR_FULL;
      return v[THR_W-1:0];
    endfunction

    function pid_result_t predict(pid_request_t req);
      pid_result_t res;
      longint r, p, y, thr, lim, kp, ki, kd, err, integ, sum, acc;
      bit rate_mode;
      int ax;
      res = '{default: '0};
      if (req.kind == KIND_MIX) begin
        r   = longint'(axis_out_store[0]);
        p   = longint'(axis_out_store[1]);
        y   = longint'(axis_out_store[2]);
        thr = longint'(req.throttle);
        res.motor_front  = motor_clamp(thr + p + r - y);
        res.motor_second = motor_clamp(thr + p - r + y);
        res.motor_third  = motor_clamp(thr - p - r - y);
        res.motor_fourth = motor_clamp(thr - p + r + y);
        return res;
      end
      if (req.axis == AXIS_NONE) return res;

      ax  = int'(req.axis);
      lim = longint'(limit_reg);
      kp  = longint'(kp_reg[GAIN_W*ax +: GAIN_W]);
      ki  = longint'(ki_reg[GAIN_W*ax +: GAIN_W]);
      kd  = longint'(kd_reg[GAIN_W*ax +: GAIN_W]);
      rate_mode = (req.axis == AXIS_YAW) && !req.yaw_angle_mode;

      if (rate_mode) begin
        err = longint'(req.setpoint) - longint'(req.rate);
      end else begin
        err = longint'(req.setpoint) - longint'(req.angle);
        if (req.axis == AXIS_YAW) begin
          if (err <= -longint'(Q12_PI)) err += longint'(Q12_TWO_PI);
          else if (err > longint'(Q12_PI)) err -= longint'(Q12_TWO_PI);
        end
      end

      integ = longint'(integ_store[ax]) + ((err * longint'(req.time_step)) >>> 16);
      if (req.hold_integral) integ = 0;
      if (integ > lim) integ = lim;
      else if (integ < -lim) integ = -lim;
      integ_store[ax] = int'(integ);

      if (rate_mode) sum = kd * err + ki * integ;
      else sum = kp * err + ki * integ - kd * longint'(req.rate);
      acc = sum >>> 8;
      if (acc > INT32_HI) acc = INT32_HI;
      else if (acc < INT32_LO) acc = INT32_LO;
      axis_out_store[ax] = int'(acc);
      res.pid_output = acc[Q12_W-1:0];
      return res;
    endfunction

    function void note_input(pid_request_t req);
      expected_q.push_back(predict(req));
    endfunction

    function void check_field(string name, logic signed [31:0] exp_v,
                              logic signed [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(pid_result_t got);
      pid_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: pid_output %0d", got.pid_output);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("pid_output", want.pid_output, got.pid_output);
      check_field("motor_front", 32'(want.motor_front), 32'(got.motor_front));
      check_field("motor_second", 32'(want.motor_second), 32'(got.motor_second));
      check_field("motor_third", 32'(want.motor_third), 32'(got.motor_third));
      check_field("motor_fourth", 32'(want.motor_fourth), 32'(got.motor_fourth));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_kind;
  logic [1:0]              in_axis;
  logic signed [IN_W-1:0]  in_setpoint;
  logic signed [IN_W-1:0]  in_angle;
  logic signed [IN_W-1:0]  in_rate;
  logic [DT_W-1:0]         in_time_step;
  logic                    in_hold_integral;
  logic                    in_yaw_angle_mode;
  logic [THR_W-1:0]        in_throttle;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [Q12_W-1:0] out_pid_output;
  logic [THR_W-1:0]        out_motor_front;
  logic [THR_W-1:0]        out_motor_second;
  logic [THR_W-1:0]        out_motor_third;
  logic [THR_W-1:0]        out_motor_fourth;
  logic                    cfg_wr_en;
  logic [1:0]              cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  attitude_scoreboard sb = new();
  bit idle_en = 1'b1;
  int cycle_count = 0;

  attitude_pid_motor_mixer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_axis           (in_axis),
    .in_setpoint       (in_setpoint),
    .in_angle          (in_angle),
    .in_rate           (in_rate),
    .in_time_step      (in_time_step),
    .in_hold_integral  (in_hold_integral),
    .in_yaw_angle_mode (in_yaw_angle_mode),
    .in_throttle       (in_throttle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pid_output    (out_pid_output),
    .out_motor_front   (out_motor_front),
    .out_motor_second  (out_motor_second),
    .out_motor_third   (out_motor_third),
    .out_motor_fourth  (out_motor_fourth),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result beats
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{out_pid_output, out_motor_front, out_motor_second,
                        out_motor_third, out_motor_fourth});
    end
  end

  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  initial begin
    int stall;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (!idle_en) begin
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall = pick_gap();
      end
    end
  end

  task automatic send_request(pid_request_t req);
    int gap;
    @(negedge clk);
    in_valid          <= 1'b1;
    in_kind           <= req.kind;
    in_axis           <= req.axis;
    in_setpoint       <= req.setpoint;
    in_angle          <= req.angle;
    in_rate           <= req.rate;
    in_time_step      <= req.time_step;
    in_hold_integral  <= req.hold_integral;
    in_yaw_angle_mode <= req.yaw_angle_mode;
    in_throttle       <= req.throttle;
    do @(posedge clk); while (!in_ready);
    sb.note_input(req);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_fields(logic kind, apmm_axis_t axis, int sp, int ang, int rt,
                             int dt, int hold, int yaw_mode, int thr);
    pid_request_t req;
    req.kind           = kind;
    req.axis           = axis;
    req.setpoint       = sp[IN_W-1:0];
    req.angle          = ang[IN_W-1:0];
    req.rate           = rt[IN_W-1:0];
    req.time_step      = dt[DT_W-1:0];
    req.hold_integral  = hold[0];
    req.yaw_angle_mode = yaw_mode[0];
    req.throttle       = thr[THR_W-1:0];
    send_request(req);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(apmm_reg_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(logic [CFG_W-1:0] kp, logic [CFG_W-1:0] ki,
                              logic [CFG_W-1:0] kd, logic [LIMIT_W-1:0] lim);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_LIMIT, CFG_W'(lim));
  endtask

  function automatic logic [CFG_W-1:0] small_gains(int hi);
    return {GAIN_W'($urandom_range(0, hi)), GAIN_W'($urandom_range(0, hi)),
            GAIN_W'($urandom_range(0, hi))};
  endfunction

  function automatic logic signed [IN_W-1:0] rand_q12();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return IN_W'($urandom_range(0, 16383) - 8192);
    if (sel < 90) return IN_W'($urandom_range(0, 2047) - 1024);
    return IN_W'($urandom);
  endfunction

  function automatic pid_request_t rand_request();
    pid_request_t req;
    req.kind           = 1'($urandom);
    req.axis           = apmm_axis_t'($urandom_range(0, 3));
    req.setpoint       = rand_q12();
    req.angle          = rand_q12();
    req.rate           = rand_q12();
    req.time_step      = ($urandom_range(0, 9) == 0) ? DT_W'($urandom)
                                                     : DT_W'($urandom_range(0, 1000));
    req.hold_integral  = ($urandom_range(0, 15) == 0);
    req.yaw_angle_mode = 1'($urandom);
    req.throttle       = THR_W'($urandom_range(0, 8191));
    return req;
  endfunction

  // mostly full control frames (roll, pitch, yaw, mix), some stray beats
  task automatic run_random(int n_items);
    pid_request_t req;
    int done;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        for (int a = 0; a < 3; a++) begin
          req = rand_request();
          req.kind = KIND_AXIS;
          req.axis = apmm_axis_t'(a);
          send_request(req);
          done++;
        end
        req = rand_request();
        req.kind = KIND_MIX;
        req.throttle = THR_W'($urandom_range(0, 4096));
        send_request(req);
        done++;
      end else begin
        req = rand_request();
        send_request(req);
        if (!(req.kind == KIND_AXIS && req.axis == AXIS_NONE)) done++;
      end
    end
    drain();
  endtask

  task automatic run_directed();
    send_fields(KIND_AXIS, AXIS_ROLL, 131071, -131072, 131071, 65535, 0, 0, 0);
    send_fields(KIND_AXIS, AXIS_ROLL, 131071, -131072, 131071, 65535, 0, 0, 0);
    send_fields(KIND_AXIS, AXIS_ROLL, -131072, 131071, -131072, 65535, 0, 0, 8191);
    send_fields(KIND_AXIS, AXIS_ROLL, 1000, 200, -50, 0, 0, 0, 0);
    send_fields(KIND_AXIS, AXIS_PITCH, 4096, 0, 0, 655, 1, 0, 0);
    send_fields(KIND_AXIS, AXIS_PITCH, -2048, 512, 300, 1000, 0, 1, 0);
    // yaw wrap around +-pi
    send_fields(KIND_AXIS, AXIS_YAW, 12868, 0, 0, 100, 0, 1, 0);
    send_fields(KIND_AXIS, AXIS_YAW, 12869, 0, 0, 100, 0, 1, 0);
    send_fields(KIND_AXIS, AXIS_YAW, 0, 12868, 0, 100, 0, 1, 0);
    send_fields(KIND_AXIS, AXIS_YAW, 0, 12867, 0, 100, 0, 1, 0);
    send_fields(KIND_AXIS, AXIS_YAW, 131071, -131072, 131071, 65535, 0, 1, 0);
    send_fields(KIND_AXIS, AXIS_YAW, -131072, 131071, -131072, 65535, 0, 1, 0);
    // yaw rate mode
    send_fields(KIND_AXIS, AXIS_YAW, 2000, 9000, -500, 2000, 0, 0, 0);
    send_fields(KIND_AXIS, AXIS_YAW, -3000, 0, 700, 2000, 1, 0, 0);
    send_fields(KIND_AXIS, AXIS_NONE, 131071, -131072, 131071, 65535, 0, 1, 4096);
    send_fields(KIND_MIX, AXIS_ROLL, 0, 0, 0, 0, 0, 0, 0);
    send_fields(KIND_MIX, AXIS_NONE, 131071, 131071, 131071, 65535, 1, 1, 4096);
    send_fields(KIND_MIX, AXIS_YAW, 0, 0, 0, 0, 0, 0, 8191);
    send_fields(KIND_AXIS, AXIS_ROLL, 100, 0, 0, 500, 1, 0, 0);
    send_fields(KIND_AXIS, AXIS_PITCH, -100, 0, 0, 500, 1, 0, 0);
    send_fields(KIND_AXIS, AXIS_YAW, 50, 0, 20, 500, 0, 0, 0);
    send_fields(KIND_MIX, AXIS_PITCH, 0, 0, 0, 0, 0, 0, 2048);
    drain();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_kind           = KIND_AXIS;
    in_axis           = AXIS_ROLL;
    in_setpoint       = '0;
    in_angle          = '0;
    in_rate           = '0;
    in_time_step      = '0;
    in_hold_integral  = 1'b0;
    in_yaw_angle_mode = 1'b0;
    in_throttle       = '0;
    cfg_wr_en         = 1'b0;
    cfg_index         = REG_KP;
    cfg_data          = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    run_random(20);

    program_regs({16'h0080, 16'h0200, 16'h0100}, {3{16'h0040}}, {3{16'h0020}},
                 LIMIT_RESET);
    run_directed();

    program_regs(small_gains(16'h0400), small_gains(16'h0200), small_gains(16'h0200),
                 LIMIT_RESET);
    run_random(300);

    program_regs({3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}}, 31'h7FFF_FFFF);
    run_random(200);

    program_regs('0, '0, '0, '0);
    run_random(100);

    idle_en = 1'b0;
    program_regs(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
                 CFG_W'({$urandom, $urandom}), LIMIT_W'($urandom));
    run_random(200);
    idle_en = 1'b1;

    program_regs(small_gains(16'h0300), small_gains(16'h0100), small_gains(16'h0100),
                 LIMIT_W'($urandom_range(0, 10000)));
    run_random(330);

    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/apmm_pkg.sv
rtl/apmm_mul.sv
rtl/attitude_pid_motor_mixer.sv
rtl/apmm_checker.sv
tb/tb_top.sv
